[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, dis, a, b) \
    label: assert property (@(posedge clk) disable iff (dis) (a) |-> (b)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, dis, a, b) \
    label: assert property (@(posedge clk) disable iff (dis) (a) |=> (b)) \
        else $error("assertion failed");

`endif

[hw/rtl/mtac_pkg.sv]
// Shared types, constants and tables of the Metropolis acceptance block.
package mtac_pkg;

    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;

    localparam logic [2:0] REG_INIT_TEMP  = 3'd0;
    localparam logic [2:0] REG_COOLING    = 3'd1;
    localparam logic [2:0] REG_INV_KB     = 3'd2;
    localparam logic [2:0] REG_INIT_E     = 3'd3;
    localparam logic [2:0] REG_INIT_ABS_E = 3'd4;

    localparam logic [31:0] TEMP_RESET    = 32'd32768000;
    localparam logic [31:0] COOLING_RESET = 32'hFFFF_FFFF;
    localparam logic [31:0] INV_KB_RESET  = 32'd760513692;
    localparam logic [31:0] BETA_RESET    = 32'd1521027;

    // ln 2 in Q0.32 and the exponent beyond which exp(-x) rounds to zero
    localparam logic [36:0] LN2_Q32  = 37'd2977044472;
    localparam logic [36:0] X_LIMIT  = 37'd122058823352;  // 41 * ln 2
    localparam logic [3:0]  EXP_TERMS = 4'd12;

    typedef struct packed {
        logic capture;
        logic mulx;
        logic ksetup;
        logic kstep;
        logic tmul;
        logic trcp;
        logic tfix;
        logic decide;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic neg;
        logic big;
        logic klast;
        logic tlast;
        logic div_busy;
        logic out_free;
    } sts_t;

    // floor(2^36 / i) for the Taylor term divisors; i of one bypasses it
    function automatic logic [35:0] recip(input logic [3:0] i);
        logic [35:0] r;
        case (i)
            4'd2:    r = 36'((64'd1 << 36) / 64'd2);
            4'd3:    r = 36'((64'd1 << 36) / 64'd3);
            4'd4:    r = 36'((64'd1 << 36) / 64'd4);
            4'd5:    r = 36'((64'd1 << 36) / 64'd5);
            4'd6:    r = 36'((64'd1 << 36) / 64'd6);
            4'd7:    r = 36'((64'd1 << 36) / 64'd7);
            4'd8:    r = 36'((64'd1 << 36) / 64'd8);
            4'd9:    r = 36'((64'd1 << 36) / 64'd9);
            4'd10:   r = 36'((64'd1 << 36) / 64'd10);
            4'd11:   r = 36'((64'd1 << 36) / 64'd11);
            4'd12:   r = 36'((64'd1 << 36) / 64'd12);
            default: r = 36'd0;
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/mtac_div.sv]
// Restoring divider for beta: one quotient bit per cycle, saturated result.
module mtac_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [47:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic        done,
    output logic [31:0] quotient
);
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [47:0] dvd_reg, dvd_next;
    logic [47:0] q_reg, q_next;
    logic [31:0] dsr_reg, dsr_next;
    logic [31:0] quot_reg, quot_next;
    logic [32:0] rem_sh;
    logic        qbit;

    always_comb begin
        rem_sh    = {rem_reg, dvd_reg[47]};
        qbit      = rem_sh >= {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        q_next    = q_reg;
        dsr_next  = dsr_reg;
        quot_next = quot_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 6'd0;
            rem_next  = 32'd0;
            dvd_next  = dividend;
            q_next    = 48'd0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            rem_next = qbit ? 32'(rem_sh - {1'b0, dsr_reg}) : rem_sh[31:0];
            dvd_next = {dvd_reg[46:0], 1'b0};
            q_next   = {q_reg[46:0], qbit};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd47) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (dsr_reg == 32'd0 || q_next[47:32] != 16'd0) begin
                    quot_next = 32'hFFFF_FFFF;
                end else begin
                    quot_next = q_next[31:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        q_reg    <= q_next;
        dsr_reg  <= dsr_next;
        quot_reg <= quot_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quot_reg;
endmodule

[hw/rtl/mtac_ctrl.sv]
// Sequencer for one Metropolis step: exponent, range reduction, series, decision.
module mtac_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  mtac_pkg::sts_t    sts,
    output mtac_pkg::cmd_t    cmd
);
    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_MULX   = 9'b000000010,
        S_KSETUP = 9'b000000100,
        S_KDIV   = 9'b000001000,
        S_TMUL   = 9'b000010000,
        S_TRCP   = 9'b000100000,
        S_TFIX   = 9'b001000000,
        S_DECIDE = 9'b010000000,
        S_FINISH = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   ready;

    assign ready    = (state_reg == S_IDLE) && !sts.div_busy;
    assign s_tready = ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                cmd.capture = s_tvalid && ready;
                if (s_tvalid && ready) state_next = S_MULX;
            end
            S_MULX: begin
                cmd.mulx   = 1'b1;
                state_next = S_KSETUP;
            end
            S_KSETUP: begin
                cmd.ksetup = 1'b1;
                state_next = (sts.neg || sts.big) ? S_DECIDE : S_KDIV;
            end
            S_KDIV: begin
                cmd.kstep = 1'b1;
                if (sts.klast) state_next = S_TMUL;
            end
            S_TMUL: begin
                cmd.tmul   = 1'b1;
                state_next = S_TRCP;
            end
            S_TRCP: begin
                cmd.trcp   = 1'b1;
                state_next = S_TFIX;
            end
            S_TFIX: begin
                cmd.tfix   = 1'b1;
                state_next = sts.tlast ? S_DECIDE : S_TMUL;
            end
            S_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (sts.out_free && !sts.div_busy) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule

[hw/rtl/mtac_dp.sv]
// Datapath: registers, multipliers, exp series, energy update and output register.
module mtac_dp #(
    parameter int ENERGY_WIDTH = 48,
    parameter int OUT_W = 136
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mtac_pkg::cmd_t                cmd,
    output mtac_pkg::sts_t                sts,
    input  logic [63:0]                   s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [OUT_W-1:0]              m_tdata,
    input  logic                          cfg_we,
    input  logic [2:0]                    cfg_idx,
    input  logic [mtac_pkg::DATA_W-1:0]   cfg_wdata,
    output logic [mtac_pkg::DATA_W-1:0]   cfg_rdata
);
    localparam int E = ENERGY_WIDTH;

    // configuration and state
    logic [31:0]        init_temp_reg, cooling_reg, inv_kb_reg;
    logic signed [E-1:0] init_e_reg, init_abs_e_reg;
    logic [31:0]        temp_reg, beta_reg;
    logic signed [E-1:0] energy_reg, abs_energy_reg;

    // item working registers
    logic [31:0]  de_reg, rnd_reg;
    logic [62:0]  x_reg;
    logic [63:0]  tprod_reg;
    logic [36:0]  rem_reg;
    logic [5:0]   k_reg;
    logic [2:0]   j_reg;
    logic [32:0]  term_reg;
    logic [33:0]  sum_reg;
    logic [3:0]   i_reg;
    logic [64:0]  prod_reg;
    logic [32:0]  y_reg;
    logic [67:0]  yr_reg;
    logic         accept_reg;

    logic                m_tvalid_reg;
    logic [OUT_W-1:0]    m_tdata_reg;

    // divider hookup
    logic        div_start, div_busy, div_done;
    logic [47:0] div_dividend;
    logic [31:0] div_divisor, div_quot;

    logic        cfg_temp, cfg_inv;
    logic [36:0] l_sh;
    logic [32:0] q0, q, rmd;
    logic [35:0] q0i;
    logic [33:0] p;
    logic signed [E:0] de_ext, e_sum, a_sum;
    logic signed [E-1:0] e_new, a_new;

    assign cfg_temp = cfg_we && (cfg_idx == mtac_pkg::REG_INIT_TEMP);
    assign cfg_inv  = cfg_we && (cfg_idx == mtac_pkg::REG_INV_KB);

    always_comb begin
        div_start    = cfg_temp || cfg_inv || cmd.ksetup;
        div_dividend = {(cfg_inv ? cfg_wdata[31:0] : inv_kb_reg), 16'd0};
        if (cfg_temp)        div_divisor = cfg_wdata[31:0];
        else if (cmd.ksetup) div_divisor = tprod_reg[63:32];
        else                 div_divisor = temp_reg;
    end

    mtac_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quot)
    );

    // series step: exact floor(y / i) from a reciprocal plus one correction
    always_comb begin
        l_sh = mtac_pkg::LN2_Q32 << j_reg;
        q0   = {1'b0, yr_reg[67:36]};
        q0i  = 36'(q0 * i_reg);
        rmd  = 33'(y_reg - q0i[32:0]);
        if (i_reg == 4'd1)            q = y_reg;
        else if (rmd >= {29'd0, i_reg}) q = 33'(q0 + 33'd1);
        else                          q = q0;
        p = sum_reg >> k_reg;
    end

    // saturating energy update
    always_comb begin
        de_ext = (E+1)'($signed(de_reg));
        e_sum  = (E+1)'(energy_reg) + de_ext;
        a_sum  = (E+1)'(abs_energy_reg) + de_ext;
        if (e_sum[E] != e_sum[E-1]) e_new = e_sum[E] ? {1'b1, {(E-1){1'b0}}} : {1'b0, {(E-1){1'b1}}};
        else                        e_new = e_sum[E-1:0];
        if (a_sum[E] != a_sum[E-1]) a_new = a_sum[E] ? {1'b1, {(E-1){1'b0}}} : {1'b0, {(E-1){1'b1}}};
        else                        a_new = a_sum[E-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_temp_reg  <= mtac_pkg::TEMP_RESET;
            cooling_reg    <= mtac_pkg::COOLING_RESET;
            inv_kb_reg     <= mtac_pkg::INV_KB_RESET;
            init_e_reg     <= '0;
            init_abs_e_reg <= '0;
            temp_reg       <= mtac_pkg::TEMP_RESET;
            beta_reg       <= mtac_pkg::BETA_RESET;
            energy_reg     <= '0;
            abs_energy_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_idx)
                    mtac_pkg::REG_INIT_TEMP: begin
                        init_temp_reg <= cfg_wdata[31:0];
                        temp_reg      <= cfg_wdata[31:0];
                    end
                    mtac_pkg::REG_COOLING: cooling_reg <= cfg_wdata[31:0];
                    mtac_pkg::REG_INV_KB:  inv_kb_reg  <= cfg_wdata[31:0];
                    mtac_pkg::REG_INIT_E: begin
                        init_e_reg <= cfg_wdata[E-1:0];
                        energy_reg <= cfg_wdata[E-1:0];
                    end
                    mtac_pkg::REG_INIT_ABS_E: begin
                        init_abs_e_reg <= cfg_wdata[E-1:0];
                        abs_energy_reg <= cfg_wdata[E-1:0];
                    end
                    default: ;
                endcase
            end
            if (div_done) beta_reg <= div_quot;
            if (cmd.ksetup) temp_reg <= tprod_reg[63:32];
            if (cmd.finish) begin
                m_tvalid_reg <= 1'b1;
                if (accept_reg) begin
                    energy_reg     <= e_new;
                    abs_energy_reg <= a_new;
                end
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            de_reg  <= s_tdata[31:0];
            rnd_reg <= s_tdata[63:32];
        end
        if (cmd.mulx) begin
            x_reg     <= 63'({1'b0, de_reg[30:0]}) * 63'(beta_reg);
            tprod_reg <= 64'(temp_reg) * 64'(cooling_reg);
        end
        if (cmd.ksetup) begin
            rem_reg  <= x_reg[36:0];
            k_reg    <= 6'd0;
            j_reg    <= 3'd5;
            term_reg <= 33'h1_0000_0000;
            sum_reg  <= 34'h1_0000_0000;
            i_reg    <= 4'd1;
        end
        if (cmd.kstep) begin
            if (rem_reg >= l_sh) begin
                rem_reg        <= rem_reg - l_sh;
                k_reg[j_reg]   <= 1'b1;
            end
            j_reg <= j_reg - 3'd1;
        end
        if (cmd.tmul) prod_reg <= 65'(term_reg) * 65'(rem_reg[31:0]);
        if (cmd.trcp) begin
            y_reg  <= prod_reg[64:32];
            yr_reg <= 68'(prod_reg[64:32]) * 68'(mtac_pkg::recip(i_reg));
        end
        if (cmd.tfix) begin
            term_reg <= q;
            sum_reg  <= i_reg[0] ? 34'(sum_reg - q) : 34'(sum_reg + q);
            i_reg    <= i_reg + 4'd1;
        end
        if (cmd.decide) begin
            accept_reg <= de_reg[31] || (!(x_reg >= 63'(mtac_pkg::X_LIMIT)) &&
                          ({2'b0, rnd_reg} < p));
        end
        if (cmd.finish) begin
            m_tdata_reg <= OUT_W'({temp_reg,
                                   (accept_reg ? a_new : abs_energy_reg),
                                   (accept_reg ? e_new : energy_reg),
                                   accept_reg});
        end
    end

    always_comb begin
        unique case (cfg_idx)
            mtac_pkg::REG_INIT_TEMP:  cfg_rdata = 64'(init_temp_reg);
            mtac_pkg::REG_COOLING:    cfg_rdata = 64'(cooling_reg);
            mtac_pkg::REG_INV_KB:     cfg_rdata = 64'(inv_kb_reg);
            mtac_pkg::REG_INIT_E:     cfg_rdata = 64'($unsigned(init_e_reg));
            mtac_pkg::REG_INIT_ABS_E: cfg_rdata = 64'($unsigned(init_abs_e_reg));
            default:                  cfg_rdata = 64'd0;
        endcase
    end

    assign sts.neg      = de_reg[31];
    assign sts.big      = x_reg >= 63'(mtac_pkg::X_LIMIT);
    assign sts.klast    = (j_reg == 3'd0);
    assign sts.tlast    = (i_reg == mtac_pkg::EXP_TERMS);
    assign sts.div_busy = div_busy;
    assign sts.out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
endmodule

[hw/rtl/metropolis_accept_with_annealing.sv]
// Top level of the Metropolis acceptance step with annealing temperature schedule.
//
//  channel   dir  handshake                 payload
//  s_        in   s_tvalid / s_tready       s_tdata: delta_energy, random_uniform
//  m_        out  m_tvalid / m_tready       m_tdata: accepted, energies, temperature
//  apb       in   psel / penable / pready   paddr, pwdata, prdata (8-byte spacing)
//
//  One transaction at a time; the next is taken only after the result has gone to
//  the output register and the bit-serial beta divider, which runs beside the
//  12-term exp series (TMUL, TRCP and TFIX for each term), has finished. Negative
//  or very large changes skip the series but still wait for the divider. Writing
//  initial_temperature or inv_boltzmann starts the divider too; s_tready stays
//  low while it runs. Reset is synchronous, active low; it loads the register
//  reset values and the matching beta. One finished result may wait in the output
//  register while the next transaction is being worked on.
module metropolis_accept_with_annealing #(
    parameter int ENERGY_WIDTH = 48
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // tdata: [31:0] delta_energy, [63:32] random_uniform
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [63:0]                   s_tdata,
    // tdata: [0] accepted, energy_now, absolute_energy_now, temperature_now, zero fill
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [((2*ENERGY_WIDTH+40)/8)*8-1:0] m_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mtac_pkg::ADDR_W-1:0]   paddr,
    input  logic [mtac_pkg::DATA_W-1:0]   pwdata,
    output logic [mtac_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    localparam int OUT_W = ((2*ENERGY_WIDTH+40)/8)*8;

    mtac_pkg::cmd_t cmd;
    mtac_pkg::sts_t sts;
    logic           cfg_we;
    logic [2:0]     cfg_idx;

    // registers sit every 8 bytes
    assign pready  = 1'b1;
    assign cfg_idx = paddr[5:3];
    assign cfg_we  = psel && penable && pwrite;

    mtac_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mtac_dp #(
        .ENERGY_WIDTH (ENERGY_WIDTH),
        .OUT_W        (OUT_W)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (pwdata),
        .cfg_rdata (prdata)
    );
endmodule

[hw/rtl/mtac_checker.sv]
// Port-level checks for the Metropolis acceptance block, bound to the top level.
`include "assert_macros.svh"

module mtac_checker #(
    parameter int ENERGY_WIDTH = 48
) (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_tvalid,
    input logic                                  s_tready,
    input logic                                  m_tvalid,
    input logic                                  m_tready,
    input logic [((2*ENERGY_WIDTH+40)/8)*8-1:0]  m_tdata
);
    `ASSERT_NEXT(a_out_hold, aclk, !aresetn, m_tvalid && !m_tready, m_tvalid)
    `ASSERT_NEXT(a_out_stable, aclk, !aresetn, m_tvalid && !m_tready, $stable(m_tdata))
    `ASSERT_NEXT(a_one_at_a_time, aclk, !aresetn, s_tvalid && s_tready, !s_tready)
    `ASSERT_NEXT(a_reset_clears, aclk, 1'b0, !aresetn, !m_tvalid)
endmodule

bind metropolis_accept_with_annealing mtac_checker #(
    .ENERGY_WIDTH (ENERGY_WIDTH)
) u_mtac_checker (.*);
